/* hw/rtl/wdt_pkg.sv */
`default_nettype none

package wdt_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_KICK  = 2'd1;
    localparam logic [1:0] KIND_CYCLE = 2'd2;

    // control register bits
    localparam int unsigned BIT_CHG = 4;
    localparam int unsigned BIT_EN  = 3;

    localparam int unsigned CTRL_W = 8;
    localparam int unsigned SEL_W  = 3;
    localparam int unsigned WIN_W  = 3;
    localparam int unsigned TIME_W = 64;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CTRL_W-1:0] write_value;
        logic [TIME_W-1:0] now_ns;
    } wdt_cmd_t;

    typedef struct packed {
        logic [CTRL_W-1:0] control_value;
        logic              reset_request;
    } wdt_res_t;

    // one item handed from the input register to the core
    typedef struct packed {
        logic     fire;
        wdt_cmd_t cmd;
    } wdt_step_t;

    // timeout period in ns for each select code
    function automatic logic [TIME_W-1:0] period_ns(input logic [SEL_W-1:0] sel);
        logic [TIME_W-1:0] p;
        case (sel)
            3'd0:    p = 64'd47000000;
            3'd1:    p = 64'd94000000;
            3'd2:    p = 64'd190000000;
            3'd3:    p = 64'd380000000;
            3'd4:    p = 64'd750000000;
            3'd5:    p = 64'd1500000000;
            3'd6:    p = 64'd3000000000;
            default: p = 64'd6000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wdt_core.sv */
`default_nettype none

module wdt_core
    import wdt_pkg::*;
#(
    parameter int unsigned CHANGE_WINDOW_CYCLES = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire wdt_step_t step,
    output wdt_res_t       res
);

    localparam logic [WIN_W-1:0] WIN_LOAD = WIN_W'(CHANGE_WINDOW_CYCLES);

    logic [CTRL_W-1:0] control_reg, control_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic [WIN_W-1:0]  win_dec;
    logic [CTRL_W-1:0] ctrl_cyc;
    logic              req;

    always_comb
    begin
        control_next  = control_reg;
        window_next   = window_reg;
        deadline_next = deadline_reg;
        req           = 1'b0;
        win_dec       = (window_reg != '0) ? window_reg - WIN_W'(1) : window_reg;
        ctrl_cyc      = control_reg;
        if (win_dec == '0)
        begin
            ctrl_cyc[BIT_CHG] = 1'b0;
        end
        case (step.cmd.kind)
            KIND_WRITE:
            begin
                if (step.cmd.write_value[BIT_EN] || control_reg[BIT_CHG])
                begin
                    control_next = step.cmd.write_value;
                end
                if (step.cmd.write_value[BIT_CHG])
                begin
                    window_next = WIN_LOAD;
                end
            end
            KIND_KICK:
            begin
                deadline_next = step.cmd.now_ns + period_ns(control_reg[SEL_W-1:0]);
            end
            KIND_CYCLE:
            begin
                window_next  = win_dec;
                control_next = ctrl_cyc;
                // timeout clears control, window count and deadline
                if (ctrl_cyc[BIT_EN] && (deadline_reg < step.cmd.now_ns))
                begin
                    req           = 1'b1;
                    control_next  = '0;
                    window_next   = '0;
                    deadline_next = '0;
                end
            end
            default:
            begin
                control_next = control_reg;
            end
        endcase
        res.control_value = control_next;
        res.reset_request = req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            window_reg   <= '0;
            deadline_reg <= '0;
        end
        else if (step.fire)
        begin
            control_reg  <= control_next;
            window_reg   <= window_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/watchdog_timer_with_timed_disable.sv */
`default_nettype none

// channel | direction | signals                       | payload
// cmd     | in        | cmd_valid, cmd_ready          | cmd_item  (kind, write_value, now_ns)
// res     | out       | res_valid, res_ready          | res_item  (control_value, reset_request)
//
// one result item per command item; sustained rate is one item per clock unless results stall
// each item passes the input register, then core logic into the result register
// the core state (control, window count, deadline) updates as the item moves to the result
// async active-low reset clears control, window count, deadline and both valid flags
// a stalled result holds the pipe; cmd_ready stays high while the input register can drain

module watchdog_timer_with_timed_disable
    import wdt_pkg::*;
#(
    parameter int unsigned CHANGE_WINDOW_CYCLES = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire wdt_cmd_t cmd_item,
    output logic          res_valid,
    input  wire logic     res_ready,
    output wdt_res_t      res_item
);

    // input register
    logic     in_valid_reg;
    wdt_cmd_t in_item_reg;

    // result register
    logic     res_valid_reg;
    wdt_res_t res_item_reg;

    logic      advance;
    wdt_step_t step;
    wdt_res_t  core_res;

    // the held item moves on when the result slot is free or being emptied
    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;

    assign step.fire = advance;
    assign step.cmd  = in_item_reg;

    wdt_core #(
        .CHANGE_WINDOW_CYCLES(CHANGE_WINDOW_CYCLES)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .res  (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            in_item_reg <= cmd_item;
        end
        if (advance)
        begin
            res_item_reg <= core_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

// checks the watchdog against an in-house model of the control register, the
// change window and the deadline, with random stalls on both channels

module tb
    import wdt_pkg::*;
;

    // kind code that the block must ignore
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int unsigned WINDOW_CYCLES = 4;
    localparam int          DIRECTED_N    = 22;
    localparam int          RANDOM_ITEMS  = 950;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 10;

    localparam logic [CTRL_W-1:0] CHG_MASK = CTRL_W'(1 << BIT_CHG);
    localparam logic [CTRL_W-1:0] EN_MASK  = CTRL_W'(1 << BIT_EN);
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // in-house model of the watchdog plus the store of expected result items
    class wdt_scoreboard;
        logic [CTRL_W-1:0] ctrl;
        logic [WIN_W-1:0]  window;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] period_tbl [8];
        int unsigned       window_len;
        wdt_res_t          expected_q [$];
        int                errors;
        int                n_items;
        int                n_results;
        int                n_timeouts;
        int                n_dropped;
        int                n_wraps;

        function new(int unsigned win);
            window_len = win;
            period_tbl = '{64'd47000000, 64'd94000000, 64'd190000000, 64'd380000000,
                           64'd750000000, 64'd1500000000, 64'd3000000000,
                           64'd6000000000};
            errors     = 0;
            n_items    = 0;
            n_results  = 0;
            n_timeouts = 0;
            n_dropped  = 0;
            n_wraps    = 0;
            clear();
        endfunction

        function void clear();
            ctrl     = '0;
            window   = '0;
            deadline = '0;
        endfunction

        // advance the model by one accepted item and queue its result
        function void note_cmd(wdt_cmd_t c);
            wdt_res_t          r;
            logic [TIME_W:0]   sum;
            r.reset_request = 1'b0;
            case (c.kind)
                KIND_WRITE:
                begin
                    if (c.write_value[BIT_EN] || ctrl[BIT_CHG])
                        ctrl = c.write_value;
                    else
                        n_dropped++;
                    if (c.write_value[BIT_CHG])
                        window = WIN_W'(window_len);
                end
                KIND_KICK:
                begin
                    sum = {1'b0, c.now_ns} + {1'b0, period_tbl[ctrl[SEL_W-1:0]]};
                    if (sum[TIME_W])
                        n_wraps++;
                    deadline = sum[TIME_W-1:0];
                end
                KIND_CYCLE:
                begin
                    if (window != 0)
                        window = window - 1'b1;
                    if (window == 0)
                        ctrl[BIT_CHG] = 1'b0;
                    if (ctrl[BIT_EN] && deadline < c.now_ns)
                    begin
                        r.reset_request = 1'b1;
                        n_timeouts++;
                        clear();
                    end
                end
                default: ;
            endcase
            r.control_value = ctrl;
            expected_q.push_back(r);
            n_items++;
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_res(wdt_res_t got);
            wdt_res_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected (ctrl %02h req %0b)",
                                 n_results, got.control_value, got.reset_request));
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.control_value !== exp_r.control_value)
                    report($sformatf("result %0d control_value %02h, expected %02h",
                                     n_results, got.control_value, exp_r.control_value));
                if (got.reset_request !== exp_r.reset_request)
                    report($sformatf("result %0d reset_request %0b, expected %0b",
                                     n_results, got.reset_request, exp_r.reset_request));
            end
            n_results++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // all block inputs start at known values
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    wdt_cmd_t cmd_item  = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    wdt_res_t res_item;

    wdt_scoreboard sb = new(WINDOW_CYCLES);

    // simulated time carried by well-formed sequences
    logic [TIME_W-1:0] now_cur   = '0;
    int                items_sent = 0;

    watchdog_timer_with_timed_disable #(
        .CHANGE_WINDOW_CYCLES(WINDOW_CYCLES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // offer one item, with an occasional gap before it, and wait for the handshake
    task automatic send(input logic [1:0] k, input logic [CTRL_W-1:0] v,
                        input logic [TIME_W-1:0] t);
        wdt_cmd_t c;
        c.kind        = k;
        c.write_value = v;
        c.now_ns      = t;
        // gaps come before 4% of items, which keeps the input idling near 10%
        // no gaps at all in the middle stretch of items
        if (!(items_sent >= 300 && items_sent < 500) && $urandom_range(0, 99) < 4)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do @(posedge clk); while (!cmd_ready);
        sb.note_cmd(c);
        items_sent++;
    endtask

    // one cpu cycle item with time moved forward by a mix of short and long steps
    task automatic tick();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            now_cur = now_cur + TIME_W'($urandom_range(0, 50000000));
        else if (pick < 90)
            now_cur = now_cur + TIME_W'($urandom_range(0, 1000000000));
        else
            now_cur = now_cur + {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
        send(KIND_CYCLE, CTRL_W'($urandom), now_cur);
    endtask

    // enable with a random period, kick, then let cycles run, kicking now and then
    task automatic arm_and_run();
        int n;
        n = $urandom_range(1, 8);
        send(KIND_WRITE, CTRL_W'($urandom) | EN_MASK, TIME_W'({$urandom, $urandom}));
        send(KIND_KICK, CTRL_W'($urandom), now_cur);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 20)
                send(KIND_KICK, CTRL_W'($urandom), now_cur);
            tick();
        end
    endtask

    // open the change window, wait some cycles, then try to switch the watchdog off
    task automatic try_disable();
        int n;
        n = $urandom_range(0, 6);
        send(KIND_WRITE, CTRL_W'($urandom) | CHG_MASK | EN_MASK, now_cur);
        repeat (n) tick();
        send(KIND_WRITE, CTRL_W'($urandom) & ~EN_MASK, now_cur);
        if ($urandom_range(0, 1) == 1)
            tick();
    endtask

    // arbitrary items, any kind including the ignored one, any time
    task automatic noise();
        repeat ($urandom_range(1, 4))
            send(2'($urandom), CTRL_W'($urandom), TIME_W'({$urandom, $urandom}));
    endtask

    // result side: random stalls, one long hold-off, and a stretch with none
    initial
    begin : receiver
        int hold;
        bit pressure_done;
        hold          = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                sb.check_res(res_item);
            // hold off long enough that the pipe fills and cmd_ready drops
            if (!pressure_done && sb.n_results >= 150)
            begin
                pressure_done = 1'b1;
                hold          = 60;
            end
            // the stretch without stalls lines up with the sender's one
            if (hold > 0)
            begin
                hold--;
                res_ready <= 1'b0;
            end
            else if (sb.n_results >= 300 && sb.n_results < 500)
                res_ready <= 1'b1;
            else
                res_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // ends the run when nothing moves on either channel for too long
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                stall = 0;
            else
                stall++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored kind, dropped writes, both period extremes, exact
        // deadline boundary, deadline wrap, window expiry and timeout clearing
        send(KIND_CYCLE, 8'h00, 64'd0);
        send(KIND_NONE, 8'hFF, TIME_MAX);
        send(KIND_WRITE, CHG_MASK, 64'd0);              // dropped, still opens window
        send(KIND_WRITE, EN_MASK, 64'd0);               // enable, shortest period
        send(KIND_KICK, 8'h00, 64'd1000);
        send(KIND_CYCLE, 8'h00, 64'd47001000);          // equal to deadline, no timeout
        send(KIND_CYCLE, 8'h00, 64'd47001001);          // just past, timeout
        send(KIND_WRITE, CHG_MASK | EN_MASK | 8'h07, 64'd0);
        send(KIND_CYCLE, 8'h00, 64'd0);
        send(KIND_WRITE, 8'h00, 64'd0);                 // disable inside the window
        send(KIND_WRITE, EN_MASK | 8'h07, 64'd0);       // longest period
        send(KIND_WRITE, 8'h00, 64'd0);                 // disable outside window, dropped
        send(KIND_KICK, 8'h00, TIME_MAX);               // deadline wraps past zero
        send(KIND_CYCLE, 8'h00, 64'd5);
        send(KIND_CYCLE, 8'h00, TIME_MAX);
        send(KIND_WRITE, CHG_MASK | EN_MASK, 64'd0);
        repeat (WINDOW_CYCLES) send(KIND_CYCLE, 8'h00, 64'd0);  // window runs out
        send(KIND_WRITE, 8'h00, 64'd0);
        send(KIND_WRITE, 8'hEF, 64'd0);

        // random: mostly well-formed arm and disable sequences, some near wrap
        while (items_sent < DIRECTED_N + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                arm_and_run();
            else if (pick < 65)
                try_disable();
            else if (pick < 75)
            begin
                now_cur = TIME_MAX - {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
                arm_and_run();
            end
            else
                noise();
        end
        cmd_valid <= 1'b0;

        // drain, then leave room for any stray result
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d results, %0d mismatches", sb.n_items,
                 sb.n_results, sb.errors);
        $display("saw %0d timeouts, %0d dropped control writes, %0d wrapped deadlines",
                 sb.n_timeouts, sb.n_dropped, sb.n_wraps);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
